// ===== src/assert_macros.svh =====
// Assertion helpers for the tape machine step unit.
// Each one samples on clk_i and is held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TMSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds.
`define TMSU_ASSERT_NEVER(lbl, cond, msg) \
  `TMSU_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/tmsu_pkg.sv =====
// ----------------------------------------------------------------------------
// tmsu_pkg
// Shared types and constants of the tape machine step unit.
// ----------------------------------------------------------------------------
package tmsu_pkg;

  // Fixed field widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned OperandW = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NextPcW  = 16;
  localparam int unsigned LogW     = 5;
  localparam int unsigned ProgLenW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Parameter defaults
  localparam int unsigned TapeAddrBitsDef = 16;
  localparam int unsigned PcBitsDef       = 16;

  // Register reset values
  localparam logic [LogW-1:0]     TapeSizeLog2Rst  = LogW'(16);
  localparam logic [ProgLenW-1:0] ProgramLengthRst = '0;

  typedef enum logic [OpW-1:0] {
    OP_PTR_ADD  = 3'd0,
    OP_CELL_ADD = 3'd1,
    OP_GET      = 3'd2,
    OP_PUT      = 3'd3,
    OP_JZ       = 3'd4,
    OP_JNZ      = 3'd5
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TAPE_SIZE_LOG2 = 2'd0,
    CFG_PROGRAM_LENGTH = 2'd1
  } cfg_reg_e;

endpackage

// ===== src/tmsu_if.sv =====
// ----------------------------------------------------------------------------
// tmsu_if
// Valid/ready channels of the tape machine step unit: configuration writes,
// instructions in, results out.
// ----------------------------------------------------------------------------
interface tmsu_cfg_if import tmsu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface tmsu_in_if import tmsu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OpW-1:0]      opcode;
  logic [OperandW-1:0] operand;
  logic [ByteW-1:0]    in_byte;

  modport source (output valid, opcode, operand, in_byte, input ready);
  modport sink   (input valid, opcode, operand, in_byte, output ready);
endinterface

interface tmsu_out_if import tmsu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NextPcW-1:0] next_pc;
  logic               out_valid;
  logic [ByteW-1:0]   out_byte;
  logic               halted;

  modport source (output valid, next_pc, out_valid, out_byte, halted, input ready);
  modport sink   (input valid, next_pc, out_valid, out_byte, halted, output ready);
endinterface

// ===== src/tmsu_tape_ram.sv =====
// ----------------------------------------------------------------------------
// tmsu_tape_ram
// Byte tape storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmsu_tape_ram import tmsu_pkg::*; #(
  parameter int unsigned ADDR_BITS = TapeAddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [ByteW-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [ByteW-1:0]     rdata_o
);

  localparam int unsigned Depth = 1 << ADDR_BITS;

  logic [ByteW-1:0] mem [Depth];
  logic [ByteW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tmsu_clear.sv =====
// ----------------------------------------------------------------------------
// tmsu_clear
// Post-reset sweep that writes zero to every tape cell, one per cycle.
// ----------------------------------------------------------------------------
module tmsu_clear import tmsu_pkg::*; #(
  parameter int unsigned ADDR_BITS = TapeAddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 busy_o,
  output logic [ADDR_BITS-1:0] addr_o
);

  logic                 busy_q, busy_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;

  // Advance through the tape, stop after the last cell
  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (busy_q) begin
      addr_d = addr_q + ADDR_BITS'(1);
      if (addr_q == {ADDR_BITS{1'b1}}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = addr_q;

endmodule

// ===== src/tape_machine_step_unit.sv =====
// ----------------------------------------------------------------------------
// tape_machine_step_unit
// Executes one compiled tape-language instruction per transaction against a
// byte tape in synchronous RAM, a data pointer and a program counter.
//
//   channel  role      contents
//   cfg_i    write     register index, data
//   in_i     sink      opcode, operand, in_byte
//   out_o    source    next_pc, out_valid, out_byte, halted
//
// One instruction per cycle while out_o takes results; an accepted instruction
// passes through the stage 1 register into the result register, which drives
// out_o valid. Stage 0 issues the tape read at the masked data pointer, stage 1
// executes and writes the cell back, with a bypass when the next instruction
// reads the cell just written.
// After reset all 2^TAPE_ADDR_BITS tape cells are swept to zero, during which
// in_i is not ready; cfg_i is always ready.
// A stalled out_o holds the result register and stage 1, then stops in_i.
// ----------------------------------------------------------------------------
module tape_machine_step_unit import tmsu_pkg::*; #(
  parameter int unsigned TAPE_ADDR_BITS = TapeAddrBitsDef,
  parameter int unsigned PC_BITS        = PcBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tmsu_cfg_if.sink        cfg_i,
  tmsu_in_if.sink         in_i,
  tmsu_out_if.source      out_o
);

  `include "assert_macros.svh"

  localparam int unsigned TA    = TAPE_ADDR_BITS;
  localparam int unsigned PcExt = (PC_BITS > NextPcW) ? PC_BITS : NextPcW;

  // Configuration registers
  logic [LogW-1:0]     tsl_q;
  logic [ProgLenW-1:0] prog_len_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsl_q      <= TapeSizeLog2Rst;
      prog_len_q <= ProgramLengthRst;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_TAPE_SIZE_LOG2: tsl_q      <= cfg_i.data[LogW-1:0];
        CFG_PROGRAM_LENGTH: prog_len_q <= cfg_i.data[ProgLenW-1:0];
        default: ;
      endcase
    end
  end

  // Tape mask from the clamped size
  logic [LogW-1:0] lg_c;
  logic [TA-1:0]   mask;

  always_comb begin
    if (tsl_q < LogW'(1)) begin
      lg_c = LogW'(1);
    end else if (tsl_q > LogW'(TA)) begin
      lg_c = LogW'(TA);
    end else begin
      lg_c = tsl_q;
    end
    for (int i = 0; i < TA; i++) begin
      mask[i] = (LogW'(i) < lg_c);
    end
  end

  // Clearing sweep
  logic          clr_busy;
  logic [TA-1:0] clr_addr;

  tmsu_clear #(.ADDR_BITS(TA)) u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .addr_o (clr_addr)
  );

  // Pipeline control
  logic s1_q, s1_d;
  logic out_v_q, out_v_d;
  logic s1_adv, in_acc;

  assign s1_adv     = s1_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !clr_busy && (!s1_q || s1_adv);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_d = s1_q;
    if (in_acc) begin
      s1_d = 1'b1;
    end else if (s1_adv) begin
      s1_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (s1_adv) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_q    <= s1_d;
      out_v_q <= out_v_d;
    end
  end

  // Stage 0: address, pointer update, tape read
  logic [TA-1:0] dp_q;
  logic [TA-1:0] rd_addr;

  assign rd_addr = dp_q & mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q <= '0;
    end else if (in_acc && (op_e'(in_i.opcode) == OP_PTR_ADD)) begin
      dp_q <= (rd_addr + in_i.operand[TA-1:0]) & mask;
    end
  end

  // Stage 1 payload
  logic [OpW-1:0]      s1_op_q;
  logic [OperandW-1:0] s1_operand_q;
  logic [ByteW-1:0]    s1_in_byte_q;
  logic [TA-1:0]       s1_addr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q      <= in_i.opcode;
      s1_operand_q <= in_i.operand;
      s1_in_byte_q <= in_i.in_byte;
      s1_addr_q    <= rd_addr;
    end
  end

  // Tape RAM with write port shared by the sweep and stage 1
  logic             ex_we;
  logic [ByteW-1:0] ex_wdata;
  logic             ram_we;
  logic [TA-1:0]    ram_waddr;
  logic [ByteW-1:0] ram_wdata;
  logic [ByteW-1:0] rdata;

  assign ram_we    = clr_busy || ex_we;
  assign ram_waddr = clr_busy ? clr_addr : s1_addr_q;
  assign ram_wdata = clr_busy ? '0 : ex_wdata;

  tmsu_tape_ram #(.ADDR_BITS(TA)) u_tape (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Bypass: a read that meets the write of the same cell sees the new byte
  logic             byp_q;
  logic [ByteW-1:0] byp_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_acc) begin
      byp_q <= ex_we && (s1_addr_q == rd_addr);
    end else if (s1_adv) begin
      byp_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byp_data_q <= ex_wdata;
    end
  end

  // Stage 1: execute
  logic [ByteW-1:0]   cur_byte;
  logic [PC_BITS-1:0] pc_q;
  logic [PC_BITS-1:0] pc_next;
  logic               put;

  assign cur_byte = byp_q ? byp_data_q : rdata;

  always_comb begin
    ex_we    = 1'b0;
    ex_wdata = cur_byte;
    put      = 1'b0;
    pc_next  = pc_q + PC_BITS'(1);
    case (op_e'(s1_op_q))
      OP_CELL_ADD: begin
        ex_we    = s1_adv;
        ex_wdata = cur_byte + s1_operand_q[ByteW-1:0];
      end
      OP_GET: begin
        ex_we    = s1_adv;
        ex_wdata = s1_in_byte_q;
      end
      OP_PUT: begin
        put = 1'b1;
      end
      OP_JZ: begin
        if (cur_byte == '0) begin
          pc_next = PC_BITS'(s1_operand_q);
        end
      end
      OP_JNZ: begin
        if (cur_byte != '0) begin
          pc_next = PC_BITS'(s1_operand_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (s1_adv) begin
      pc_q <= pc_next;
    end
  end

  // Result register
  logic [PcExt-1:0]   pc_ext;
  logic [NextPcW-1:0] out_pc_q;
  logic               out_put_q;
  logic [ByteW-1:0]   out_byte_q;
  logic               out_halt_q;

  assign pc_ext = PcExt'(pc_next);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pc_q   <= pc_ext[NextPcW-1:0];
      out_put_q  <= put;
      out_byte_q <= put ? cur_byte : '0;
      out_halt_q <= (pc_ext == PcExt'(prog_len_q));
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.next_pc   = out_pc_q;
  assign out_o.out_valid = out_put_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.halted    = out_halt_q;

  // Checks
  `TMSU_ASSERT(a_byp_needs_s1, byp_q |-> s1_q, "bypass set without an instruction in stage 1")
  `TMSU_ASSERT(a_we_source, ram_we |-> (s1_q || clr_busy), "tape write with no source")
  `TMSU_ASSERT(a_clear_empty, $fell(clr_busy) |-> (!s1_q && !out_v_q), "pipeline busy during clear")

endmodule

// ===== bench/tape_machine_step_unit_test.sv =====
// ----------------------------------------------------------------------------
// tape_machine_step_unit_test
// Self-checking bench for the tape machine step unit. Instructions go in on
// the in_i channel and every accepted one runs through a local predictor of
// the tape, data pointer and program counter. Results coming out of out_o
// are checked field by field, in order, against the predicted ones. Both
// channel ends idle at random, and the result side is held off for a long
// stretch once so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tape_machine_step_unit_test;
  import tmsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TapeCells  = 1 << TapeAddrBitsDef;

  // Opcodes outside op_e and register indexes outside cfg_reg_e
  localparam logic [OpW-1:0]     OpSpare6     = 3'd6;
  localparam logic [OpW-1:0]     OpSpare7     = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare3 = 2'd3;

  typedef struct packed {
    logic [NextPcW-1:0] next_pc;
    logic               out_valid;
    logic [ByteW-1:0]   out_byte;
    logic               halted;
  } step_result_t;

  logic clk_i;
  logic rst_ni;

  tmsu_cfg_if cfg_bus ();
  tmsu_in_if  instr_bus ();
  tmsu_out_if result_bus ();

  tape_machine_step_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (instr_bus),
    .out_o  (result_bus)
  );

  // Predictor state
  logic [ByteW-1:0]    tape_image [TapeCells];
  logic [15:0]         ptr_model;
  logic [NextPcW-1:0]  pc_model;
  logic [LogW-1:0]     size_log2_model;
  logic [ProgLenW-1:0] prog_len_model;

  step_result_t expected_results [$];
  int unsigned  mismatches  = 0;
  int unsigned  cycle_count = 0;

  // Flow control knobs
  bit   tx_eager = 1'b0;
  logic rx_eager = 1'b0;
  logic rx_block = 1'b0;
  int unsigned rx_wait;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  // Mask of tape cells in use, with the size clamped into the legal range
  function automatic int unsigned live_tape_mask();
    int unsigned lg;
    lg = size_log2_model;
    if (lg < 1) lg = 1;
    if (lg > TapeAddrBitsDef) lg = TapeAddrBitsDef;
    return (32'd1 << lg) - 1;
  endfunction

  // Execute one instruction on the predictor and return its result
  function automatic step_result_t predict_step(input logic [OpW-1:0] op,
                                                input logic [OperandW-1:0] operand,
                                                input logic [ByteW-1:0] inb);
    step_result_t       res;
    int unsigned        mask;
    int unsigned        addr;
    logic [NextPcW-1:0] next;
    mask = live_tape_mask();
    addr = ptr_model & mask;
    next = pc_model + 1'b1;
    res  = '0;
    case (op)
      OP_PTR_ADD:  ptr_model = 16'((addr + operand) & mask);
      OP_CELL_ADD: tape_image[addr] = tape_image[addr] + operand[ByteW-1:0];
      OP_GET:      tape_image[addr] = inb;
      OP_PUT: begin
        res.out_valid = 1'b1;
        res.out_byte  = tape_image[addr];
      end
      OP_JZ:  if (tape_image[addr] == '0) next = operand;
      OP_JNZ: if (tape_image[addr] != '0) next = operand;
      default: ;
    endcase
    pc_model    = next;
    res.next_pc = next;
    res.halted  = (next == prog_len_model);
    return res;
  endfunction

  // Result side: random gaps per transaction, quiet mode, long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      rx_wait = 0;
    end else if (rx_block) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        rx_wait = rx_eager ? 0 : $urandom_range(0, 6);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_checker
    step_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, next_pc", 0, result_bus.next_pc);
      end else begin
        want = expected_results.pop_front();
        if (result_bus.next_pc !== want.next_pc)
          report_mismatch("next_pc", want.next_pc, result_bus.next_pc);
        if (result_bus.out_valid !== want.out_valid)
          report_mismatch("out_valid", want.out_valid, result_bus.out_valid);
        if (result_bus.out_byte !== want.out_byte)
          report_mismatch("out_byte", want.out_byte, result_bus.out_byte);
        if (result_bus.halted !== want.halted)
          report_mismatch("halted", want.halted, result_bus.halted);
      end
    end
  end

  // Hold the result side off for a number of cycles
  task automatic hold_results(input int unsigned cycles);
    rx_block <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_block <= 1'b0;
  endtask

  // Offer one instruction and record its prediction once accepted
  task automatic send_instr(input logic [OpW-1:0] op, input logic [OperandW-1:0] operand,
                            input logic [ByteW-1:0] inb);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      instr_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_bus.valid   <= 1'b1;
    instr_bus.opcode  <= op;
    instr_bus.operand <= operand;
    instr_bus.in_byte <= inb;
    do @(posedge clk_i); while (!(instr_bus.valid && instr_bus.ready));
    expected_results.push_back(predict_step(op, operand, inb));
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    instr_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // One register write; the caller drops valid after its last write
  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    case (idx)
      CFG_TAPE_SIZE_LOG2: size_log2_model = data[LogW-1:0];
      CFG_PROGRAM_LENGTH: prog_len_model  = data[ProgLenW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CfgDataW-1:0] log2_data,
                           input logic [ProgLenW-1:0] prog_len);
    write_register(CFG_TAPE_SIZE_LOG2, log2_data);
    write_register(CFG_PROGRAM_LENGTH, prog_len);
    cfg_bus.valid <= 1'b0;
  endtask

  // Draw one instruction, biased toward short pointer moves and nearby jumps
  task automatic issue_random_instr(input int unsigned prog_len);
    int unsigned         pick;
    logic [OperandW-1:0] operand;
    logic [ByteW-1:0]    inb;
    logic [OpW-1:0]      op;
    pick = $urandom_range(0, 99);
    inb  = ByteW'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      operand = OperandW'($urandom);
    end else if ($urandom_range(0, 1) == 0) begin
      operand = OperandW'($urandom_range(0, 3));
    end else begin
      operand = OperandW'(32'hFFFF - $urandom_range(0, 2));
    end
    if (pick < 18) begin
      op = OP_PTR_ADD;
    end else if (pick < 40) begin
      op = OP_CELL_ADD;
    end else if (pick < 50) begin
      op = OP_GET;
      if ($urandom_range(0, 2) == 0) inb = '0;
    end else if (pick < 62) begin
      op = OP_PUT;
    end else if (pick < 94) begin
      op = (pick < 78) ? OP_JZ : OP_JNZ;
      if ($urandom_range(0, 4) != 0) operand = OperandW'($urandom_range(0, prog_len));
    end else begin
      op = $urandom_range(0, 1) ? OpSpare6 : OpSpare7;
    end
    send_instr(op, operand, inb);
  endtask

  task automatic run_random_phase(input logic [LogW-1:0] log2, input logic [ProgLenW-1:0] prog_len,
                                  input int unsigned count, input bit tx_quiet,
                                  input bit rx_quiet);
    logic [CfgDataW-1:0] log2_data;
    log2_data = {11'($urandom), log2};
    configure(log2_data, prog_len);
    tx_eager = tx_quiet;
    rx_eager <= rx_quiet;
    repeat (count) issue_random_instr(prog_len);
    drain_results();
    tx_eager = 1'b0;
    rx_eager <= 1'b0;
  endtask

  // Every opcode, operand extremes, taken and untaken jumps, counter wrap
  task automatic test_operations();
    send_instr(OP_PUT,      16'h0000, 8'h00);
    send_instr(OP_JZ,       16'hFFFF, 8'hFF);
    send_instr(OP_JNZ,      16'h0005, 8'h00);
    send_instr(OP_CELL_ADD, 16'hFFFF, 8'h00);
    send_instr(OP_PUT,      16'h0000, 8'hFF);
    send_instr(OP_JNZ,      16'h1234, 8'h00);
    send_instr(OP_JZ,       16'h0000, 8'h00);
    send_instr(OP_GET,      16'hFFFF, 8'h00);
    send_instr(OP_JZ,       16'h0042, 8'h00);
    send_instr(OP_GET,      16'h0000, 8'hFF);
    send_instr(OP_GET,      16'h0000, 8'hA5);
    send_instr(OP_PTR_ADD,  16'hFFFF, 8'h00);
    send_instr(OP_PUT,      16'h0000, 8'h00);
    send_instr(OP_PTR_ADD,  16'h0001, 8'h00);
    send_instr(OP_PUT,      16'hFFFF, 8'h00);
    send_instr(OpSpare6,    16'hFFFF, 8'hFF);
    send_instr(OpSpare7,    16'h0000, 8'h00);
    send_instr(OP_CELL_ADD, 16'h0180, 8'h00);
    send_instr(OP_PUT,      16'h0000, 8'h00);
    drain_results();
  endtask

  // Size clamping at both ends, ignored indexes, halt at the top of the range
  task automatic test_register_writes();
    write_register(CFG_TAPE_SIZE_LOG2, 16'hFFE0);
    write_register(CFG_PROGRAM_LENGTH, 16'hFFFF);
    write_register(CfgIdxSpare2, 16'hFFFF);
    write_register(CfgIdxSpare3, 16'h0000);
    cfg_bus.valid <= 1'b0;
    send_instr(OP_PTR_ADD, 16'h0003, 8'h00);
    send_instr(OP_PUT,     16'h0000, 8'h00);
    send_instr(OP_JZ,      16'hFFFF, 8'h00);
    send_instr(OP_JNZ,     16'hFFFF, 8'h00);
    drain_results();
    configure(16'h001F, 16'h0000);
    send_instr(OP_PTR_ADD, 16'h7FFF, 8'h00);
    send_instr(OP_PUT,     16'h0000, 8'h00);
    drain_results();
  endtask

  // Stall the result side long enough for the input to back up
  task automatic test_output_backpressure();
    configure(16'h0002, 16'h000A);
    tx_eager = 1'b1;
    fork
      hold_results(400);
    join_none
    repeat (120) issue_random_instr(10);
    drain_results();
    tx_eager = 1'b0;
  endtask

  // Random programs across tape sizes, program lengths and idling modes
  task automatic test_random_programs();
    run_random_phase(5'd1,  16'd8,     300, 1'b0, 1'b0);
    run_random_phase(5'd3,  16'd24,    250, 1'b1, 1'b1);
    run_random_phase(5'd16, 16'hFFFF,  250, 1'b0, 1'b0);
    run_random_phase(5'd0,  16'd0,     200, 1'b0, 1'b1);
    run_random_phase(5'd31, 16'd100,   200, 1'b1, 1'b0);
    run_random_phase(5'd5,  16'd12,    300, 1'b0, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < TapeCells; i++) tape_image[i] = '0;
    ptr_model       = '0;
    pc_model        = '0;
    size_log2_model = TapeSizeLog2Rst;
    prog_len_model  = ProgramLengthRst;

    rst_ni = 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= '0;
    cfg_bus.data      <= '0;
    instr_bus.valid   <= 1'b0;
    instr_bus.opcode  <= '0;
    instr_bus.operand <= '0;
    instr_bus.in_byte <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operations();
    test_register_writes();
    test_output_backpressure();
    test_random_programs();

    // Let the pipeline settle before the verdict
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
